/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the conv3x3 sign threshold block.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on posedge clk, ignored while rst_n is low.
`define C3ST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every posedge clk, reset included.
`define C3ST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C3ST_ASSERT(lbl, prop, msg)
`define C3ST_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/c3st_pkg.sv */
// ---------------------------------------------------------------------------
// c3st_pkg
// Frame geometry, kernel coefficients and the types shared by the
// conv3x3 sign threshold block.
// ---------------------------------------------------------------------------
package c3st_pkg;

  localparam int WIDTH  = 1920;
  localparam int HEIGHT = 1080;

  localparam int COL_W = $clog2(WIDTH);
  localparam int ROW_W = $clog2(HEIGHT);
  localparam int POS_W = 11;
  localparam int PIX_W = 8;
  localparam int SUM_W = 16;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(HEIGHT - 1);

  localparam logic [PIX_W-1:0] VAL_LO = 8'd0;
  localparam logic [PIX_W-1:0] VAL_HI = 8'd255;

  // Coefficients scaled by 200, indexed [row][col], row 0 is the row above.
  localparam logic signed [6:0] KERN [3][3] = '{
    '{ 7'sd25, -7'sd28,  7'sd10},
    '{-7'sd28,  7'sd0,  -7'sd15},
    '{ 7'sd10, -7'sd15,  7'sd25}
  };

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } out_t;

  // [wr][wc]: [2][2] is the newest pixel, [0][0] the oldest corner.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // Per window row / column: 1 if that tap lies inside the frame.
  // Bit 3 stands for the row or column past the window and is always 0.
  typedef struct packed {
    logic [3:0] row_ok;
    logic [3:0] col_ok;
  } bound_ok_t;

endpackage

/* design/conv3x3_sign_threshold_top.sv */
// ---------------------------------------------------------------------------
// conv3x3_sign_threshold_top
// 3x3 convolution with sign threshold on a raster grey pixel stream.
// ---------------------------------------------------------------------------
// Takes one pixel per clock, save where a result burst or an output stall
// holds the input. Each pixel passes an input stage (line memory read), a
// window stage and an output register before its result leaves.
// Results trail the input by one row and one column. A pixel in the last
// column gives two results, in the last row two, and the final pixel of a
// frame four; these leave one after another through the one kernel
// unit, and the input is stalled meanwhile. frame_start forces the pixel
// to row 0, column 0; pending centres of an unfinished frame are dropped.
// Neighbours outside the frame count as zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3x3_sign_threshold_top import c3st_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic             acc;
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_adv;
  logic [PIX_W-1:0] lb_above;
  logic [PIX_W-1:0] lb_two;
  logic [3:0]       s1_mask;
  bound_ok_t        s1_bnd;

  win_t             win_r;
  win_t             win_nxt;

  logic             s2_valid_r;
  logic [3:0]       s2_mask_r;
  logic [3:0]       s2_mask_left;
  bound_ok_t        s2_bnd_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic [1:0]       sel;
  logic             emit;
  logic             s2_done;
  logic             s2_ready;
  logic [ROW_W-1:0] cen_row;
  logic [COL_W-1:0] cen_col;
  logic [PIX_W-1:0] k_value;

  logic             out_valid_r;
  out_t             out_data_r;
  logic             out_free;

  // ---- input stage and position counters ----
  assign acc   = in_valid && !in_stall;
  assign r_cur = in_data.frame_start ? '0 : row_cnt_r;
  assign c_cur = in_data.frame_start ? '0 : col_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (acc) begin
      if (c_cur == COL_MAX) begin
        col_cnt_r <= '0;
        row_cnt_r <= (r_cur == ROW_MAX) ? '0 : r_cur + ROW_W'(1);
      end else begin
        row_cnt_r <= r_cur;
        col_cnt_r <= c_cur + COL_W'(1);
      end
    end
  end

  c3st_linebuf u_linebuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .addr      (c_cur),
    .pix       (in_data.pixel),
    .above     (lb_above),
    .two_above (lb_two)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_data.pixel;
      s1_row_r <= r_cur;
      s1_col_r <= c_cur;
    end
  end

  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  // ---- window stage ----
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = lb_two;
    win_nxt[1][2] = lb_above;
    win_nxt[2][2] = s1_pix_r;
  end

  // results owed, in order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
  always_comb begin
    s1_mask[0] = (s1_row_r != '0) && (s1_col_r != '0);
    s1_mask[1] = (s1_row_r != '0) && (s1_col_r == COL_MAX);
    s1_mask[2] = (s1_row_r == ROW_MAX) && (s1_col_r != '0);
    s1_mask[3] = (s1_row_r == ROW_MAX) && (s1_col_r == COL_MAX);
    s1_bnd.row_ok = {1'b0, 1'b1, s1_row_r != '0, s1_row_r > ROW_W'(1)};
    s1_bnd.col_ok = {1'b0, 1'b1, s1_col_r != '0, s1_col_r > COL_W'(1)};
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r    <= win_nxt;
      s2_bnd_r <= s1_bnd;
      s2_row_r <= s1_row_r;
      s2_col_r <= s1_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_mask_r  <= '0;
    end else if (s1_adv) begin
      s2_valid_r <= (s1_mask != '0);
      s2_mask_r  <= s1_mask;
    end else if (emit) begin
      s2_valid_r <= !s2_done;
      s2_mask_r  <= s2_mask_left;
    end
  end

  // ---- result sequencing through the shared kernel ----
  always_comb begin
    if (s2_mask_r[0]) begin
      sel = 2'd0;
    end else if (s2_mask_r[1]) begin
      sel = 2'd1;
    end else if (s2_mask_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign s2_mask_left = s2_mask_r & (s2_mask_r - 4'd1);
  assign emit         = s2_valid_r && out_free;
  assign s2_done      = emit && (s2_mask_left == '0);
  assign s2_ready     = !s2_valid_r || s2_done;

  assign cen_row = sel[1] ? s2_row_r : s2_row_r - ROW_W'(1);
  assign cen_col = sel[0] ? s2_col_r : s2_col_r - COL_W'(1);

  c3st_kernel u_kernel (
    .win   (win_r),
    .oy    (sel[1]),
    .ox    (sel[0]),
    .bnd   (s2_bnd_r),
    .value (k_value)
  );

  // ---- output register ----
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.value <= k_value;
      out_data_r.row   <= POS_W'(cen_row);
      out_data_r.col   <= POS_W'(cen_col);
      out_data_r.last  <= (s2_mask_left == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  `C3ST_ASSERT(a_cnt_bound, (col_cnt_r <= COL_MAX) && (row_cnt_r <= ROW_MAX), "position counter out of frame")
  `C3ST_ASSERT(a_s2_owes, s2_valid_r |-> (s2_mask_r != '0), "window stage held with no result owed")
  `C3ST_ASSERT(a_burst, (out_valid && !out_stall && !out_data.last) |=> out_valid, "gap inside a result burst")
  `C3ST_ASSERT(a_stall_src, in_stall |-> (s1_valid_r && s2_valid_r), "input stalled with nothing held")

endmodule

/* design/c3st_linebuf.sv */
// ---------------------------------------------------------------------------
// c3st_linebuf
// Two line memories holding the previous two rows. The row above is read
// and overwritten in the same cycle; the row two above is written in the
// next cycle with the value just read, with a bypass for a same-column read.
// ---------------------------------------------------------------------------
module c3st_linebuf import c3st_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [COL_W-1:0] addr,
  input  logic [PIX_W-1:0] pix,
  output logic [PIX_W-1:0] above,
  output logic [PIX_W-1:0] two_above
);

  logic [PIX_W-1:0] above_mem [WIDTH];
  logic [PIX_W-1:0] two_mem   [WIDTH];

  logic [PIX_W-1:0] above_rd_r;
  logic [PIX_W-1:0] two_rd_r;
  logic [PIX_W-1:0] byp_d_r;
  logic             byp_r;
  logic             wr_pend_r;
  logic [COL_W-1:0] wr_addr_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      above_rd_r      <= above_mem[addr];
      above_mem[addr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      two_mem[wr_addr_r] <= above_rd_r;
    end
    if (acc) begin
      two_rd_r <= two_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= acc;
    end
  end

  // a read landing on the column whose delayed write is still pending
  always_ff @(posedge clk) begin
    if (acc) begin
      wr_addr_r <= addr;
      byp_r     <= wr_pend_r && (addr == wr_addr_r);
      byp_d_r   <= above_rd_r;
    end
  end

  assign above     = above_rd_r;
  assign two_above = byp_r ? byp_d_r : two_rd_r;

endmodule

/* design/c3st_kernel.sv */
// ---------------------------------------------------------------------------
// c3st_kernel
// One 3x3 kernel sum over a window, centred at a chosen offset, with taps
// outside the frame forced to zero, and its sign threshold.
// ---------------------------------------------------------------------------
module c3st_kernel import c3st_pkg::*; (
  input  win_t             win,
  input  logic             oy,
  input  logic             ox,
  input  bound_ok_t        bnd,
  output logic [PIX_W-1:0] value
);

  logic [1:0]              wr;
  logic [1:0]              wc;
  logic [PIX_W-1:0]        tv;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    sum  = '0;
    wr   = '0;
    wc   = '0;
    tv   = '0;
    term = '0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        wr = 2'(dy) + 2'(oy);
        wc = 2'(dx) + 2'(ox);
        // index 3 falls past the window: row_ok/col_ok bit 3 is zero
        tv = (bnd.row_ok[wr] && bnd.col_ok[wc]) ? win[wr[1:0]][wc[1:0]] : '0;
        term = SUM_W'(KERN[dy][dx]) * SUM_W'(signed'({1'b0, tv}));
        sum  = sum + term;
      end
    end
    value = sum[SUM_W-1] ? VAL_LO : VAL_HI;
  end

endmodule
